// ----- rtl/tpwm_pkg.sv -----
// Shared types and constants of the three-phase PWM edge scheduler.
package tpwm_pkg;

  // Event command codes
  localparam logic [2:0] CMD_START    = 3'd0;
  localparam logic [2:0] CMD_HI_OFF_A = 3'd1;
  localparam logic [2:0] CMD_LO_ON_A  = 3'd2;
  localparam logic [2:0] CMD_HI_OFF_B = 3'd3;
  localparam logic [2:0] CMD_LO_ON_B  = 3'd4;
  localparam logic [2:0] CMD_HI_OFF_C = 3'd5;
  localparam logic [2:0] CMD_LO_ON_C  = 3'd6;
  localparam logic [2:0] CMD_ALL_OFF  = 3'd7;

  // Exit modes
  localparam logic [1:0] MODE_EXIT = 2'd0;
  localparam logic [1:0] MODE_WAIT = 2'd1;
  localparam logic [1:0] MODE_LOOP = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_CYCLE_COUNT    = 2'd0;
  localparam logic [1:0] REG_DEAD_TIME      = 2'd1;
  localparam logic [1:0] REG_LOOP_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_WAIT_THRESHOLD = 2'd3;

  // Reset values of the configuration registers
  localparam logic [15:0] RST_CYCLE_COUNT    = 16'd1600;
  localparam logic [11:0] RST_DEAD_TIME      = 12'd16;
  localparam logic [11:0] RST_LOOP_THRESHOLD = 12'd8;
  localparam logic [11:0] RST_WAIT_THRESHOLD = 12'd64;

  localparam int NUM_PHASE_EVT = 6;
  localparam logic [2:0] SLOT_LAST = 3'd7;

  // Command of each unsorted phase event, in command-code order
  localparam logic [2:0] PHASE_CMD [NUM_PHASE_EVT] = '{
    CMD_HI_OFF_A, CMD_LO_ON_A, CMD_HI_OFF_B, CMD_LO_ON_B, CMD_HI_OFF_C, CMD_LO_ON_C
  };

  typedef struct packed {
    logic [15:0] cycle_count;
    logic [11:0] dead_time;
    logic [11:0] loop_threshold;
    logic [11:0] wait_threshold;
  } cfg_t;

endpackage

// ----- rtl/tpwm_if.sv -----
// Request channel interfaces: on-time input and schedule event output.
interface tpwm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] on_time_a;
  logic [15:0] on_time_b;
  logic [15:0] on_time_c;

  modport source (output valid, output on_time_a, output on_time_b, output on_time_c,
                  input ready);
  modport sink (input valid, input on_time_a, input on_time_b, input on_time_c,
                output ready);
endinterface

interface tpwm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] delta_count;
  logic [1:0]  exit_mode;
  logic [2:0]  slot;
  logic        last;

  modport source (output valid, output command, output delta_count, output exit_mode,
                  output slot, output last, input ready);
  modport sink (input valid, input command, input delta_count, input exit_mode,
                input slot, input last, output ready);
endinterface

// ----- rtl/three_phase_pwm_edge_scheduler_unit.sv -----
// Top level of the three-phase PWM edge scheduler with dead time.
//
// Each input request carries three high-side on-times (phases A, B, C) and
// produces the eight-event schedule of one PWM cycle: START, the six phase
// edges sorted by time (ties in command-code order), then ALL-OFF, each with
// its delta from the previous event and an exit mode chosen by the loop and
// wait thresholds. Three phase lanes saturate the on-times and form the
// high-off and low-on times in parallel; a merge stage ranks these times and
// a schedule buffer turns them into deltas; an emitter sends one event per
// cycle while the output is ready. A request therefore occupies eight event
// slots at the output port, and that single port sets the sustained rate.
// The next request is taken while the previous schedule drains, so back-to-
// back requests stream with no gap. The lane registers load on the edge that
// accepts a request; the merge, buffer and output registers follow in that
// order, and a stall at the output port can hold any of them.
// COUNT_BITS sets the width of all internal times; deltas wider than 16 bits
// are truncated on the output while the exit mode still sees the full value.
// Write configuration only while no request is in flight.
module three_phase_pwm_edge_scheduler_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  tpwm_in_if.sink     in_ch,
  tpwm_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int W = COUNT_BITS;
  localparam int N = tpwm_pkg::NUM_PHASE_EVT;

  tpwm_pkg::cfg_t      cfg_r;
  logic                lane_vld_r;
  logic                lane_vld_nxt;
  logic                lane_load;
  logic                merge_rdy;
  logic                merge_vld;
  logic                emit_rdy;
  logic [N-1:0][W-1:0] evt_time;
  logic [N-1:0][W-1:0] sorted_time;
  logic [N-1:0][2:0]   sorted_cmd;
  logic [15:0]         on_time [3];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycle_count    <= tpwm_pkg::RST_CYCLE_COUNT;
      cfg_r.dead_time      <= tpwm_pkg::RST_DEAD_TIME;
      cfg_r.loop_threshold <= tpwm_pkg::RST_LOOP_THRESHOLD;
      cfg_r.wait_threshold <= tpwm_pkg::RST_WAIT_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpwm_pkg::REG_CYCLE_COUNT:    cfg_r.cycle_count    <= cfg_wdata;
        tpwm_pkg::REG_DEAD_TIME:      cfg_r.dead_time      <= cfg_wdata[11:0];
        tpwm_pkg::REG_LOOP_THRESHOLD: cfg_r.loop_threshold <= cfg_wdata[11:0];
        tpwm_pkg::REG_WAIT_THRESHOLD: cfg_r.wait_threshold <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Lane stage: accept while empty or while the merge stage takes its contents
  assign in_ch.ready = !lane_vld_r || merge_rdy;
  assign lane_load   = in_ch.valid && in_ch.ready;

  always_comb begin
    lane_vld_nxt = lane_vld_r;
    if (lane_load) begin
      lane_vld_nxt = 1'b1;
    end else if (merge_rdy) begin
      lane_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_vld_r <= 1'b0;
    end else begin
      lane_vld_r <= lane_vld_nxt;
    end
  end

  assign on_time[0] = in_ch.on_time_a;
  assign on_time[1] = in_ch.on_time_b;
  assign on_time[2] = in_ch.on_time_c;

  // One lane per phase; even slots hold high-side off, odd slots low-side on
  for (genvar p = 0; p < 3; p++) begin : g_lane
    tpwm_lane #(.W(W)) u_lane (
      .clk      (clk),
      .load     (lane_load),
      .cfg      (cfg_r),
      .on_time  (on_time[p]),
      .hi_off_r (evt_time[2*p]),
      .lo_on_r  (evt_time[2*p+1])
    );
  end

  tpwm_merge #(.W(W)) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (lane_vld_r),
    .in_rdy        (merge_rdy),
    .evt_time      (evt_time),
    .out_vld       (merge_vld),
    .out_rdy       (emit_rdy),
    .sorted_time_r (sorted_time),
    .sorted_cmd_r  (sorted_cmd)
  );

  tpwm_emit #(.W(W)) u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_vld      (merge_vld),
    .in_rdy      (emit_rdy),
    .sorted_time (sorted_time),
    .sorted_cmd  (sorted_cmd),
    .out_ch      (out_ch)
  );

endmodule

// ----- rtl/tpwm_lane.sv -----
// One phase lane: saturate the on-time and register its high-off and low-on times.
module tpwm_lane #(
  parameter int W = 16
) (
  input  logic             clk,
  input  logic             load,
  input  tpwm_pkg::cfg_t   cfg,
  input  logic [15:0]      on_time,
  output logic [W-1:0]     hi_off_r,
  output logic [W-1:0]     lo_on_r
);

  localparam int XW = W + 2;

  logic [XW-1:0] cyc_x;
  logic [XW-1:0] dt_x;
  logic [XW-1:0] two_dt;
  logic          no_room;
  logic [W-1:0]  limit;
  logic [W-1:0]  sat_lo;
  logic [W-1:0]  t;
  logic [W-1:0]  dt;
  logic [W:0]    t_plus_dt;
  logic          clip;
  logic [W-1:0]  hi_off_nxt;
  logic [W-1:0]  lo_on_nxt;

  assign cyc_x     = XW'(W'(cfg.cycle_count));
  assign dt        = W'(cfg.dead_time);
  assign dt_x      = XW'(dt);
  assign two_dt    = dt_x << 1;
  assign no_room   = cyc_x < (two_dt + XW'(1));
  assign limit     = W'(cyc_x - two_dt);
  // clipped low-side time: (limit - 1) + dead time
  assign sat_lo    = W'(cyc_x - dt_x - XW'(1));
  assign t         = W'(on_time);
  assign t_plus_dt = {1'b0, t} + {1'b0, dt};
  assign clip      = t >= limit;

  always_comb begin
    if (no_room) begin
      hi_off_nxt = '0;
      lo_on_nxt  = dt;
    end else if (clip) begin
      hi_off_nxt = limit - W'(1);
      lo_on_nxt  = sat_lo;
    end else begin
      hi_off_nxt = t;
      lo_on_nxt  = t_plus_dt[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hi_off_r <= hi_off_nxt;
      lo_on_r  <= lo_on_nxt;
    end
  end

endmodule

// ----- rtl/tpwm_merge.sv -----
// Merge stage: rank the six lane edge times and register them in stable order.
module tpwm_merge #(
  parameter int W = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_vld,
  output logic                                     in_rdy,
  input  logic [tpwm_pkg::NUM_PHASE_EVT-1:0][W-1:0] evt_time,
  output logic                                     out_vld,
  input  logic                                     out_rdy,
  output logic [tpwm_pkg::NUM_PHASE_EVT-1:0][W-1:0] sorted_time_r,
  output logic [tpwm_pkg::NUM_PHASE_EVT-1:0][2:0]   sorted_cmd_r
);

  localparam int N = tpwm_pkg::NUM_PHASE_EVT;

  logic                  vld_r;
  logic                  vld_nxt;
  logic                  load;
  logic [N-1:0][2:0]     rank;
  logic [N-1:0][W-1:0]   sorted_time_nxt;
  logic [N-1:0][2:0]     sorted_cmd_nxt;

  assign in_rdy  = !vld_r || out_rdy;
  assign load    = in_vld && in_rdy;
  assign out_vld = vld_r;

  // Rank = events strictly earlier, plus ties that sit at a lower index
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank[i] = 3'd0;
      for (int j = 0; j < N; j++) begin
        if (j != i) begin
          if ((evt_time[j] < evt_time[i]) || ((evt_time[j] == evt_time[i]) && (j < i))) begin
            rank[i] = rank[i] + 3'd1;
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      sorted_time_nxt[k] = '0;
      sorted_cmd_nxt[k]  = '0;
      for (int i = 0; i < N; i++) begin
        if (rank[i] == 3'(k)) begin
          sorted_time_nxt[k] = evt_time[i];
          sorted_cmd_nxt[k]  = tpwm_pkg::PHASE_CMD[i];
        end
      end
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_rdy) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sorted_time_r <= sorted_time_nxt;
      sorted_cmd_r  <= sorted_cmd_nxt;
    end
  end

endmodule

// ----- rtl/tpwm_emit.sv -----
// Schedule buffer and emitter: build eight deltas, send one event per ready cycle.
module tpwm_emit #(
  parameter int W = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  tpwm_pkg::cfg_t                           cfg,
  input  logic                                     in_vld,
  output logic                                     in_rdy,
  input  logic [tpwm_pkg::NUM_PHASE_EVT-1:0][W-1:0] sorted_time,
  input  logic [tpwm_pkg::NUM_PHASE_EVT-1:0][2:0]   sorted_cmd,
  tpwm_out_if.source                               out_ch
);

  localparam int N  = tpwm_pkg::NUM_PHASE_EVT;
  localparam int DW = (W > 12) ? W : 12;

  logic [W-1:0]  delta_r [8];
  logic [2:0]    cmd_r [8];
  logic [W-1:0]  delta_nxt [8];
  logic [2:0]    cmd_nxt [8];
  logic          buf_vld_r;
  logic          buf_vld_nxt;
  logic [2:0]    slot_r;
  logic [2:0]    slot_nxt;
  logic          out_vld_r;
  logic          out_vld_nxt;
  logic          take;
  logic          pop;
  logic          load;
  logic [W-1:0]  cyc_w;
  logic [W-1:0]  dt_w;
  logic [W-1:0]  alloff;
  logic [W-1:0]  sel_delta;
  logic [DW-1:0] sel_delta_x;
  logic [1:0]    sel_mode;
  logic [2:0]    command_r;
  logic [15:0]   delta_count_r;
  logic [1:0]    exit_mode_r;
  logic [2:0]    slot_out_r;
  logic          last_r;

  assign take   = !out_vld_r || out_ch.ready;
  assign pop    = buf_vld_r && take;
  assign in_rdy = !buf_vld_r || (pop && (slot_r == tpwm_pkg::SLOT_LAST));
  assign load   = in_vld && in_rdy;

  assign cyc_w  = W'(cfg.cycle_count);
  assign dt_w   = W'(cfg.dead_time);
  assign alloff = (cyc_w >= dt_w) ? (cyc_w - dt_w) : '0;

  // Sorted times never decrease, so each phase delta is a plain difference
  always_comb begin
    delta_nxt[0] = dt_w;
    cmd_nxt[0]   = tpwm_pkg::CMD_START;
    delta_nxt[1] = sorted_time[0];
    cmd_nxt[1]   = sorted_cmd[0];
    for (int k = 1; k < N; k++) begin
      delta_nxt[k+1] = sorted_time[k] - sorted_time[k-1];
      cmd_nxt[k+1]   = sorted_cmd[k];
    end
    delta_nxt[7] = (alloff >= sorted_time[N-1]) ? (alloff - sorted_time[N-1]) : '0;
    cmd_nxt[7]   = tpwm_pkg::CMD_ALL_OFF;
  end

  assign sel_delta   = delta_r[slot_r];
  assign sel_delta_x = DW'(sel_delta);

  always_comb begin
    if (sel_delta_x <= DW'(cfg.loop_threshold)) begin
      sel_mode = tpwm_pkg::MODE_LOOP;
    end else if (sel_delta_x <= DW'(cfg.wait_threshold)) begin
      sel_mode = tpwm_pkg::MODE_WAIT;
    end else begin
      sel_mode = tpwm_pkg::MODE_EXIT;
    end
  end

  always_comb begin
    buf_vld_nxt = buf_vld_r;
    slot_nxt    = slot_r;
    out_vld_nxt = out_vld_r;
    if (pop) begin
      slot_nxt    = slot_r + 3'd1;
      out_vld_nxt = 1'b1;
      if (slot_r == tpwm_pkg::SLOT_LAST) begin
        buf_vld_nxt = 1'b0;
      end
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (load) begin
      buf_vld_nxt = 1'b1;
      slot_nxt    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
      slot_r    <= 3'd0;
      out_vld_r <= 1'b0;
    end else begin
      buf_vld_r <= buf_vld_nxt;
      slot_r    <= slot_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 8; k++) begin
        delta_r[k] <= delta_nxt[k];
        cmd_r[k]   <= cmd_nxt[k];
      end
    end
    if (pop) begin
      command_r     <= cmd_r[slot_r];
      delta_count_r <= 16'(sel_delta);
      exit_mode_r   <= sel_mode;
      slot_out_r    <= slot_r;
      last_r        <= (slot_r == tpwm_pkg::SLOT_LAST);
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.command     = command_r;
  assign out_ch.delta_count = delta_count_r;
  assign out_ch.exit_mode   = exit_mode_r;
  assign out_ch.slot        = slot_out_r;
  assign out_ch.last        = last_r;

endmodule

// ----- rtl/tpwm_checker.sv -----
// Port-level checks of the schedule output, bound to the top level.
module tpwm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_command,
  input logic [15:0] out_delta_count,
  input logic [1:0]  out_exit_mode,
  input logic [2:0]  out_slot,
  input logic        out_last
);

  // Hold a stalled event
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command)
      && $stable(out_delta_count) && $stable(out_slot))
    else $error("stalled event changed");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event presented right after reset");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_slot == tpwm_pkg::SLOT_LAST)))
    else $error("last flag does not match final slot");

  a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_slot == 3'd0) == (out_command == tpwm_pkg::CMD_START))
      && ((out_slot == tpwm_pkg::SLOT_LAST) == (out_command == tpwm_pkg::CMD_ALL_OFF)))
    else $error("START or ALL-OFF in wrong slot");

  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_exit_mode == tpwm_pkg::MODE_EXIT)
      || (out_exit_mode == tpwm_pkg::MODE_WAIT) || (out_exit_mode == tpwm_pkg::MODE_LOOP))
    else $error("undefined exit mode");

endmodule

bind three_phase_pwm_edge_scheduler_unit tpwm_checker u_tpwm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_command     (out_ch.command),
  .out_delta_count (out_ch.delta_count),
  .out_exit_mode   (out_ch.exit_mode),
  .out_slot        (out_ch.slot),
  .out_last        (out_ch.last)
);

// ----- tb/pwm_schedule_checker.sv -----
// Schedule checker: predicts the eight-event schedule of each request and compares it.
module pwm_schedule_checker (
  input  logic        clk,
  input  logic        rst_n,
  tpwm_in_if          in_ch,
  tpwm_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] delta_count;
    logic [1:0]  exit_mode;
    logic [2:0]  slot;
    logic        last;
  } sched_evt_t;

  tpwm_pkg::cfg_t regs;
  sched_evt_t     expected_events[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [1:0] exit_mode_for(input logic [31:0] delta);
    if (delta <= 32'(regs.loop_threshold)) return tpwm_pkg::MODE_LOOP;
    if (delta <= 32'(regs.wait_threshold)) return tpwm_pkg::MODE_WAIT;
    return tpwm_pkg::MODE_EXIT;
  endfunction

  function automatic void add_event(input logic [2:0] cmd, input logic [31:0] delta,
                                    input logic [2:0] slot_no);
    sched_evt_t ev;
    ev.command     = cmd;
    ev.delta_count = delta[15:0];
    ev.exit_mode   = exit_mode_for(delta);
    ev.slot        = slot_no;
    ev.last        = (slot_no == tpwm_pkg::SLOT_LAST);
    expected_events.push_back(ev);
  endfunction

  // Build the whole schedule of one request: saturate, sort stably, form deltas.
  function automatic void predict_schedule(input logic [15:0] on_a, input logic [15:0] on_b,
                                           input logic [15:0] on_c);
    logic [31:0] cyc, dt, limit, t, run, alloff, key_t;
    logic [31:0] evt_time [tpwm_pkg::NUM_PHASE_EVT];
    logic [2:0]  evt_cmd  [tpwm_pkg::NUM_PHASE_EVT];
    logic [15:0] phase_on [3];
    logic [2:0]  key_c;
    int          i, j;
    cyc = 32'(regs.cycle_count);
    dt  = 32'(regs.dead_time);
    phase_on[0] = on_a;
    phase_on[1] = on_b;
    phase_on[2] = on_c;
    for (i = 0; i < 3; i++) begin
      t = 32'(phase_on[i]);
      if (cyc < 32'd2 * dt + 32'd1) begin
        t = '0;
      end else begin
        limit = cyc - 32'd2 * dt;
        if (t >= limit) t = limit - 32'd1;
      end
      evt_time[2*i]   = t;
      evt_cmd[2*i]    = tpwm_pkg::PHASE_CMD[2*i];
      evt_time[2*i+1] = (t + dt) & 32'hFFFF;
      evt_cmd[2*i+1]  = tpwm_pkg::PHASE_CMD[2*i+1];
    end
    for (i = 1; i < tpwm_pkg::NUM_PHASE_EVT; i++) begin
      key_t = evt_time[i];
      key_c = evt_cmd[i];
      j = i - 1;
      while (j >= 0 && evt_time[j] > key_t) begin
        evt_time[j+1] = evt_time[j];
        evt_cmd[j+1]  = evt_cmd[j];
        j--;
      end
      evt_time[j+1] = key_t;
      evt_cmd[j+1]  = key_c;
    end
    add_event(tpwm_pkg::CMD_START, dt, 3'd0);
    run = '0;
    for (i = 0; i < tpwm_pkg::NUM_PHASE_EVT; i++) begin
      add_event(evt_cmd[i], (evt_time[i] >= run) ? evt_time[i] - run : 32'd0, 3'(i + 1));
      if (evt_time[i] > run) run = evt_time[i];
    end
    alloff = (cyc >= dt) ? cyc - dt : 32'd0;
    add_event(tpwm_pkg::CMD_ALL_OFF, (alloff >= run) ? alloff - run : 32'd0,
              tpwm_pkg::SLOT_LAST);
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    sched_evt_t want;
    if (!rst_n) begin
      regs.cycle_count    = tpwm_pkg::RST_CYCLE_COUNT;
      regs.dead_time      = tpwm_pkg::RST_DEAD_TIME;
      regs.loop_threshold = tpwm_pkg::RST_LOOP_THRESHOLD;
      regs.wait_threshold = tpwm_pkg::RST_WAIT_THRESHOLD;
      expected_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tpwm_pkg::REG_CYCLE_COUNT:    regs.cycle_count    = cfg_wdata;
          tpwm_pkg::REG_DEAD_TIME:      regs.dead_time      = cfg_wdata[11:0];
          tpwm_pkg::REG_LOOP_THRESHOLD: regs.loop_threshold = cfg_wdata[11:0];
          tpwm_pkg::REG_WAIT_THRESHOLD: regs.wait_threshold = cfg_wdata[11:0];
          default: ;
        endcase
      end
      // compare before queueing: no event may leave in the cycle its request enters
      if (out_ch.valid && out_ch.ready) begin
        if (expected_events.size() == 0) begin
          $error("unexpected schedule event: command %0d slot %0d delta %0d",
                 out_ch.command, out_ch.slot, out_ch.delta_count);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("command", want.command, out_ch.command);
          check_field("delta_count", want.delta_count, out_ch.delta_count);
          check_field("exit_mode", want.exit_mode, out_ch.exit_mode);
          check_field("slot", want.slot, out_ch.slot);
          check_field("last", want.last, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_schedule(in_ch.on_time_a, in_ch.on_time_b, in_ch.on_time_c);
    end
    pending = expected_events.size();
  end

endmodule

// ----- tb/three_phase_pwm_edge_scheduler_unit_tb.sv -----
// Testbench top: drives on-time requests and register writes, gives the verdict.
module three_phase_pwm_edge_scheduler_unit_tb;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;

  // knobs that steer the request driver and the event sink
  bit          in_idle_en;
  bit          out_idle_en;
  bit          hold_armed;

  // current register values, mirrored only to steer the random on-times
  logic [15:0] cur_cycle;
  logic [15:0] cur_dead;
  logic [15:0] prev_on;

  tpwm_in_if  in_ch ();
  tpwm_out_if out_ch ();

  three_phase_pwm_edge_scheduler_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pwm_schedule_checker sched_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Event sink: drive ready at the falling edge. Once hold_armed rises, hold
  // ready low for a long stretch so the block fills up and stalls its input;
  // after that fall back to random idling until hold_armed drops again.
  initial begin : event_sink
    int hold_count;
    bit hold_done;
    out_ch.ready = 1'b0;
    hold_count   = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_armed) begin
        hold_count = 0;
        hold_done  = 1'b0;
      end
      if (hold_armed && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_count++;
        if (hold_count >= 300) hold_done = 1'b1;
      end else if (out_idle_en) begin
        out_ch.ready <= ($urandom_range(99) >= 13);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request; enter and leave at a falling edge. Valid stays high on
  // return so that back-to-back requests stream without a gap.
  task automatic send_request(input logic [15:0] on_a, input logic [15:0] on_b,
                              input logic [15:0] on_c);
    while (in_idle_en && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.on_time_a <= on_a;
    in_ch.on_time_b <= on_b;
    in_ch.on_time_c <= on_c;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid, wait until the whole schedule in flight has drained, then
  // write all four registers back to back.
  task automatic apply_config(input logic [15:0] cyc, input logic [11:0] dt,
                              input logic [11:0] loop_th, input logic [11:0] wait_th);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tpwm_pkg::REG_CYCLE_COUNT;
    cfg_wdata <= cyc;
    @(negedge clk);
    cfg_index <= tpwm_pkg::REG_DEAD_TIME;
    cfg_wdata <= {4'd0, dt};
    @(negedge clk);
    cfg_index <= tpwm_pkg::REG_LOOP_THRESHOLD;
    cfg_wdata <= {4'd0, loop_th};
    @(negedge clk);
    cfg_index <= tpwm_pkg::REG_WAIT_THRESHOLD;
    cfg_wdata <= {4'd0, wait_th};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_cycle = cyc;
    cur_dead  = {4'd0, dt};
  endtask

  // Mix of full-range values (every bit toggles), values around the
  // saturation limit, ties with the previous on-time (same time, or one dead
  // time later so a high-off lands on a low-on), and in-cycle values.
  function automatic logic [15:0] random_on_time();
    int          limit;
    int          pick;
    int unsigned value;
    limit = int'(cur_cycle) - 2 * int'(cur_dead);
    pick  = $urandom_range(99);
    if (pick < 20) begin
      value = $urandom_range(65535);
    end else if (pick < 30 && limit >= 1) begin
      value = limit - 1 + $urandom_range(2);
    end else if (pick < 45) begin
      value = $urandom_range(1) ? prev_on : prev_on + cur_dead;
    end else begin
      value = $urandom_range(cur_cycle);
    end
    if (value > 65535) value = 65535;
    prev_on = value[15:0];
    return value[15:0];
  endfunction

  // One random phase: a fresh register setting, then a run of requests.
  task automatic random_phase(input int n_req);
    int unsigned band;
    int unsigned cyc;
    int unsigned dt;
    int unsigned dt_max;
    int unsigned loop_th;
    int unsigned wait_th;
    band = $urandom_range(9);
    if (band < 2) cyc = $urandom_range(200, 16);
    else if (band < 8) cyc = $urandom_range(5000, 200);
    else cyc = $urandom_range(65535, 5000);
    dt_max = (cyc / 3 > 4095) ? 4095 : cyc / 3;
    dt = ($urandom_range(9) < 7) ? $urandom_range(dt_max) : $urandom_range(4095);
    loop_th = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(200);
    wait_th = ($urandom_range(3) == 0) ? $urandom_range(4095)
                                       : loop_th + $urandom_range(800);
    if (wait_th > 4095) wait_th = 4095;
    apply_config(cyc[15:0], dt[11:0], loop_th[11:0], wait_th[11:0]);
    repeat (n_req) send_request(random_on_time(), random_on_time(), random_on_time());
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = tpwm_pkg::REG_CYCLE_COUNT;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.on_time_a = '0;
    in_ch.on_time_b = '0;
    in_ch.on_time_c = '0;
    in_idle_en      = 1'b1;
    out_idle_en     = 1'b1;
    hold_armed      = 1'b0;
    cur_cycle       = tpwm_pkg::RST_CYCLE_COUNT;
    cur_dead        = {4'd0, tpwm_pkg::RST_DEAD_TIME};
    prev_on         = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting: 1600-count cycle, 16 dead time, limit 1568.
    send_request(16'd0, 16'd0, 16'd0);                // every high-off ties at 0, every low-on at 16
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF);       // saturate every phase
    send_request(16'd1567, 16'd1568, 16'd1569);       // just below, at, above limit
    send_request(16'd100, 16'd116, 16'd132);          // high-off lands on previous low-on
    send_request(16'd1500, 16'd800, 16'd100);         // reverse phase order
    send_request(16'd8, 16'd9, 16'd200);              // deltas at and above loop threshold
    send_request(16'd64, 16'd65, 16'd1000);           // deltas at and above wait threshold
    send_request(16'h5555, 16'hAAAA, 16'h00FF);
    send_request(16'd300, 16'd300, 16'd316);
    send_request(16'd1, 16'd0, 16'd2);
    send_request(16'd0, 16'd16, 16'd32);

    // Widest cycle and dead time, loop threshold above wait threshold.
    apply_config(16'hFFFF, 12'hFFF, 12'hFFF, 12'd0);
    send_request(16'd0, 16'hFFFF, 16'd30000);
    send_request(16'hFFFF, 16'd0, 16'd57344);

    // Shortest cycle, no dead time, zero thresholds.
    apply_config(16'd16, 12'd0, 12'd0, 12'd0);
    send_request(16'd15, 16'd16, 16'd0);
    send_request(16'd7, 16'd7, 16'd7);

    // Limit of exactly one: every on-time pinned to zero.
    apply_config(16'd33, 12'd16, 12'd0, 12'hFFF);
    send_request(16'd0, 16'd5, 16'hFFFF);

    // Dead time too large: all-off falls before the last low-on.
    apply_config(16'd100, 12'd60, 12'd10, 12'd20);
    send_request(16'd50, 16'd0, 16'hFFFF);

    // Dead time above the whole cycle: all-off time floors at zero.
    apply_config(16'd16, 12'hFFF, 12'hFFF, 12'hFFF);
    send_request(16'd1, 16'd2, 16'd3);

    // Random phases; one streams with no idling, one holds the sink off.
    random_phase(25);
    random_phase(25);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    random_phase(25);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    random_phase(25);
    // Hold the sink off while requests keep coming, so the block fills up.
    hold_armed = 1'b1;
    repeat (25) send_request(random_on_time(), random_on_time(), random_on_time());
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    hold_armed = 1'b0;
    random_phase(25);
    random_phase(25);
    random_phase(25);

    // Drain, then give any stray late event time to show up.
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 500000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
